>>> design/smoothed_fire_alarm_detector_defines.svh
// Assertion macros for the smoothed fire alarm detector.
`ifndef SMOOTHED_FIRE_ALARM_DETECTOR_DEFINES_SVH
`define SMOOTHED_FIRE_ALARM_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SFAD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfad: assertion failed");
`define SFAD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfad: assertion failed");
`else
`define SFAD_ASSERT_IMP(name, ante, cons)
`define SFAD_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> design/sfad_pkg.sv
package sfad_pkg;

	localparam int RAW_WINDOW    = 5;
	localparam int HISTORY_DEPTH = 30;

	localparam int SAMPLE_W = 16;
	localparam int RISE_W   = 10;
	localparam int NEED_W   = 5;
	localparam int DIFF_W   = SAMPLE_W + 1;

	localparam int RAW_AW     = $clog2(RAW_WINDOW);
	localparam int RAW_CNT_W  = $clog2(RAW_WINDOW + 1);
	localparam int HIST_AW    = $clog2(HISTORY_DEPTH);
	localparam int HIST_CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int MAX_N      = (RAW_WINDOW > HISTORY_DEPTH) ? RAW_WINDOW : HISTORY_DEPTH;
	localparam int IDX_W      = $clog2(MAX_N + 1);
	localparam int CMP_W      = (HIST_CNT_W > NEED_W) ? HIST_CNT_W : NEED_W;

	localparam int SUM_W   = SAMPLE_W + $clog2(RAW_WINDOW);
	localparam int RECIP_K = SUM_W + $clog2(RAW_WINDOW);
	localparam int PROD_W  = SUM_W + RECIP_K;
	localparam int QUOT_W  = SAMPLE_W + 1;
	localparam logic [RECIP_K-1:0] RECIP_M =
		RECIP_K'((2 ** RECIP_K + RAW_WINDOW - 1) / RAW_WINDOW);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_RISE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NEED = 2'd2;

	localparam logic [RISE_W-1:0]   RISE_RST = RISE_W'(8);
	localparam logic [SAMPLE_W-1:0] FIRE_RST = SAMPLE_W'(58);
	localparam logic [NEED_W-1:0]   NEED_RST = NEED_W'(27);

	typedef struct packed {
		logic [RISE_W-1:0]   rise;
		logic [SAMPLE_W-1:0] fire;
		logic [NEED_W-1:0]   need;
	} cfg_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_REQ,
		C_RAW_NOT_FULL,
		C_NOT_ARMED,
		C_RAW_MORE,
		C_HIST_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t S_IDLE   = 4'd0;
	localparam step_t S_CHECK  = 4'd1;
	localparam step_t S_SUM    = 4'd2;
	localparam step_t S_MUL    = 4'd3;
	localparam step_t S_WRITE  = 4'd4;
	localparam step_t S_OLDEST = 4'd5;
	localparam step_t S_FIRST  = 4'd6;
	localparam step_t S_SCAN   = 4'd7;
	localparam step_t S_LAST   = 4'd8;
	localparam step_t S_EMIT   = 4'd9;

	typedef struct packed {
		logic  take;
		logic  acc_clr;
		logic  acc_add;
		logic  idx_clr;
		logic  idx_inc;
		logic  mul;
		logic  wr_hist;
		logic  rd_idx;
		logic  cap_oldest;
		logic  hot_clr;
		logic  hot_add;
		logic  emit;
		logic  ret;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic raw_full;
		logic armed;
		logic raw_last;
		logic hist_last;
		logic out_busy;
	} stat_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '0;
		c.cond = C_NEVER;
		c.target = S_IDLE;
		case (s)
			S_IDLE: begin
				c.take = 1'b1;
				c.cond = C_NO_REQ;
				c.target = S_IDLE;
			end
			S_CHECK: begin
				c.acc_clr = 1'b1;
				c.idx_clr = 1'b1;
				c.cond = C_RAW_NOT_FULL;
				c.target = S_EMIT;
			end
			S_SUM: begin
				c.acc_add = 1'b1;
				c.idx_inc = 1'b1;
				c.cond = C_RAW_MORE;
				c.target = S_SUM;
			end
			S_MUL: begin
				c.mul = 1'b1;
			end
			S_WRITE: begin
				c.wr_hist = 1'b1;
			end
			S_OLDEST: begin
				c.idx_clr = 1'b1;
				c.hot_clr = 1'b1;
				c.cond = C_NOT_ARMED;
				c.target = S_EMIT;
			end
			S_FIRST: begin
				c.cap_oldest = 1'b1;
				c.rd_idx = 1'b1;
				c.idx_inc = 1'b1;
			end
			S_SCAN: begin
				c.hot_add = 1'b1;
				c.rd_idx = 1'b1;
				c.idx_inc = 1'b1;
				c.cond = C_HIST_MORE;
				c.target = S_SCAN;
			end
			S_LAST: begin
				c.hot_add = 1'b1;
			end
			S_EMIT: begin
				c.emit = 1'b1;
				c.ret = 1'b1;
				c.cond = C_OUT_BUSY;
				c.target = S_EMIT;
			end
			default: begin
				c.ret = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

>>> design/sfad_ram.sv
module sfad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 30
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> design/sfad_sequencer.sv
module sfad_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  sfad_pkg::stat_t st,
	output sfad_pkg::ctrl_t ctrl
);

	import sfad_pkg::*;

	step_t pc_q;
	logic  jump;

	assign ctrl = ucode(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:        jump = 1'b0;
			C_NO_REQ:       jump = !st.in_valid;
			C_RAW_NOT_FULL: jump = !st.raw_full;
			C_NOT_ARMED:    jump = !st.armed;
			C_RAW_MORE:     jump = !st.raw_last;
			C_HIST_MORE:    jump = !st.hist_last;
			C_OUT_BUSY:     jump = st.out_busy;
			default:        jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (jump) begin
			pc_q <= ctrl.target;
		end else if (ctrl.ret) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_q + step_t'(1);
		end
	end

endmodule

>>> design/sfad_datapath.sv
module sfad_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sfad_pkg::ctrl_t                   ctrl,
	input  sfad_pkg::cfg_t                    cfg,
	output sfad_pkg::stat_t                   st,
	input  logic                              in_valid,
	input  logic signed [sfad_pkg::SAMPLE_W-1:0] sample,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic signed [sfad_pkg::SAMPLE_W-1:0] smoothed_value,
	output logic                              smoothed_valid,
	output logic                              armed,
	output logic                              alarm
);

	import sfad_pkg::*;

	logic [SAMPLE_W-1:0]   raw_q [RAW_WINDOW];
	logic [RAW_CNT_W-1:0]  raw_cnt_q;
	logic [HIST_CNT_W-1:0] hist_cnt_q;
	logic [HIST_AW-1:0]    wp_q;
	logic [IDX_W-1:0]      idx_q;
	logic [SUM_W-1:0]      acc_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  neg_q;
	logic [SAMPLE_W-1:0]   newest_q;
	logic                  valid_q;
	logic                  rise_hit_q;
	logic [HIST_CNT_W-1:0] hot_q;
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   value_q;
	logic                  svalid_q;
	logic                  armed_q;
	logic                  alarm_q;

	logic                  in_fire;
	logic                  emit_fire;
	logic [SUM_W-1:0]      acc_mag;
	logic [QUOT_W-1:0]     quot;
	logic [SAMPLE_W-1:0]   smooth;
	logic [HIST_AW-1:0]    ram_addr;
	logic [SAMPLE_W-1:0]   ram_rdata;
	logic [DIFF_W-1:0]     diff;
	logic                  armed_now;
	logic                  hot_hit;

	assign in_fire   = ctrl.take && in_valid;
	assign armed_now = (hist_cnt_q == HIST_CNT_W'(HISTORY_DEPTH));

	assign st.in_valid  = in_valid;
	assign st.raw_full  = (raw_cnt_q == RAW_CNT_W'(RAW_WINDOW));
	assign st.armed     = armed_now;
	assign st.raw_last  = (idx_q == IDX_W'(RAW_WINDOW - 1));
	assign st.hist_last = (idx_q == IDX_W'(HISTORY_DEPTH - 1));
	assign st.out_busy  = out_valid_q && out_stall;

	assign emit_fire = ctrl.emit && !st.out_busy;

	assign acc_mag = acc_q[SUM_W-1] ? (~acc_q + SUM_W'(1)) : acc_q;
	assign quot    = prod_q[RECIP_K +: QUOT_W];
	assign smooth  = neg_q ? SAMPLE_W'(~quot + QUOT_W'(1)) : SAMPLE_W'(quot);

	assign ram_addr = ctrl.rd_idx ? idx_q[HIST_AW-1:0] : wp_q;

	assign diff = {newest_q[SAMPLE_W-1], newest_q} - {ram_rdata[SAMPLE_W-1], ram_rdata};
	assign hot_hit = CMP_W'(hot_q) >= CMP_W'(cfg.need);

	sfad_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ctrl.wr_hist),
		.addr (ram_addr),
		.wdata(smooth),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_q[0] <= sample;
			for (int i = 1; i < RAW_WINDOW; i++) begin
				raw_q[i] <= raw_q[i-1];
			end
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + SUM_W'($signed(raw_q[idx_q[RAW_AW-1:0]]));
		end
		if (ctrl.mul) begin
			prod_q <= PROD_W'(acc_mag) * PROD_W'(RECIP_M);
			neg_q  <= acc_q[SUM_W-1];
		end
		if (ctrl.wr_hist) begin
			newest_q <= smooth;
		end
		if (ctrl.cap_oldest) begin
			rise_hit_q <= $signed(diff) >= $signed({{(DIFF_W-RISE_W){1'b0}}, cfg.rise});
		end
		if (ctrl.hot_clr) begin
			hot_q <= '0;
		end else if (ctrl.hot_add && ($signed(ram_rdata) >= $signed(cfg.fire))) begin
			hot_q <= hot_q + HIST_CNT_W'(1);
		end
		if (emit_fire) begin
			value_q  <= (hist_cnt_q != '0) ? newest_q : '0;
			svalid_q <= valid_q;
			armed_q  <= armed_now;
			alarm_q  <= armed_now && (rise_hit_q || hot_hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_cnt_q   <= '0;
			hist_cnt_q  <= '0;
			wp_q        <= '0;
			idx_q       <= '0;
			valid_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_q <= 1'b0;
				if (raw_cnt_q != RAW_CNT_W'(RAW_WINDOW)) begin
					raw_cnt_q <= raw_cnt_q + RAW_CNT_W'(1);
				end
			end
			if (ctrl.wr_hist) begin
				valid_q <= 1'b1;
				if (!armed_now) begin
					hist_cnt_q <= hist_cnt_q + HIST_CNT_W'(1);
				end
				if (wp_q == HIST_AW'(HISTORY_DEPTH - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + HIST_AW'(1);
				end
			end
			if (ctrl.idx_clr) begin
				idx_q <= '0;
			end else if (ctrl.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_value = value_q;
	assign smoothed_valid = svalid_q;
	assign armed          = armed_q;
	assign alarm          = alarm_q;

endmodule

>>> design/smoothed_fire_alarm_detector.sv
// Smoothed fire alarm detector. Each request carries one signed 16-bit temperature
// sample; the block averages the latest 5 samples (truncated toward zero), keeps the
// latest 30 averages in a RAM and, once 30 exist, reports armed and raises alarm on a
// rise of at least rise_threshold from oldest to newest average, or when at least
// hot_count_needed averages are at or above fire_temperature. One result per request.
// A microcoded sequencer runs the work: a 5-step window sum once the raw window is full,
// and once armed a 30-entry history scan through the single RAM read port. The next
// request is taken once the result has entered the output register. Registers (APB,
// byte address 4*i): 0 rise_threshold, 1 fire_temperature, 2 hot_count_needed.
`include "smoothed_fire_alarm_detector_defines.svh"

module smoothed_fire_alarm_detector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [sfad_pkg::PADDR_W-1:0]          paddr,
	input  logic [sfad_pkg::PDATA_W-1:0]          pwdata,
	output logic [sfad_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [sfad_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [sfad_pkg::SAMPLE_W-1:0]  smoothed_value,
	output logic                                  smoothed_valid,
	output logic                                  armed,
	output logic                                  alarm
);

	import sfad_pkg::*;

	cfg_t                 cfg_q;
	ctrl_t                ctrl;
	stat_t                st;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise <= RISE_RST;
			cfg_q.fire <= FIRE_RST;
			cfg_q.need <= NEED_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RISE: cfg_q.rise <= pwdata[RISE_W-1:0];
				REG_FIRE: cfg_q.fire <= pwdata[SAMPLE_W-1:0];
				REG_NEED: cfg_q.need <= pwdata[NEED_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RISE: prdata = {{(PDATA_W-RISE_W){1'b0}}, cfg_q.rise};
			REG_FIRE: prdata = {{(PDATA_W-SAMPLE_W){cfg_q.fire[SAMPLE_W-1]}}, cfg_q.fire};
			REG_NEED: prdata = {{(PDATA_W-NEED_W){1'b0}}, cfg_q.need};
			default:  prdata = '0;
		endcase
	end

	assign in_stall = !ctrl.take;

	sfad_sequencer u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.ctrl  (ctrl)
	);

	sfad_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cfg           (cfg_q),
		.st            (st),
		.in_valid      (in_valid),
		.sample        (sample),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.smoothed_value(smoothed_value),
		.smoothed_valid(smoothed_valid),
		.armed         (armed),
		.alarm         (alarm)
	);

	`SFAD_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)
	`SFAD_ASSERT_IMP(a_armed_has_value, out_valid && armed, smoothed_valid)
	`SFAD_ASSERT_IMP(a_alarm_when_armed, out_valid && alarm, armed)
	`SFAD_ASSERT_IMP(a_zero_without_value, out_valid && !smoothed_valid && !armed, smoothed_value == '0)

endmodule

>>> tb/smoothed_fire_alarm_checker.sv
module smoothed_fire_alarm_checker
	import sfad_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]         pwdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [SAMPLE_W-1:0] smoothed_value,
	input  logic                       smoothed_valid,
	input  logic                       armed,
	input  logic                       alarm,
	output int                         failures,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       valid;
		logic                       armed;
		logic                       alarm;
	} reading_t;

	logic signed [SAMPLE_W-1:0] raw_win [RAW_WINDOW];
	logic signed [SAMPLE_W-1:0] smooth_hist [HISTORY_DEPTH];
	int raw_fill;
	int hist_fill;
	logic [RISE_W-1:0] rise_min;
	logic signed [SAMPLE_W-1:0] hot_level;
	logic [NEED_W-1:0] hot_needed;

	reading_t expected_readings [$];
	reading_t want;
	reading_t got;
	int mismatches;
	int reading_no;

	function automatic reading_t smooth_and_detect(input logic signed [SAMPLE_W-1:0] s);
		reading_t r;
		int i;
		int sum;
		int rise;
		int hot;
		r = '0;
		for (i = RAW_WINDOW - 1; i > 0; i--)
			raw_win[i] = raw_win[i - 1];
		raw_win[0] = s;
		if (raw_fill < RAW_WINDOW)
			raw_fill++;
		if (raw_fill == RAW_WINDOW) begin
			sum = 0;
			for (i = 0; i < RAW_WINDOW; i++)
				sum += int'(raw_win[i]);
			for (i = HISTORY_DEPTH - 1; i > 0; i--)
				smooth_hist[i] = smooth_hist[i - 1];
			smooth_hist[0] = SAMPLE_W'(sum / RAW_WINDOW);
			if (hist_fill < HISTORY_DEPTH)
				hist_fill++;
			r.valid = 1'b1;
		end
		if (hist_fill > 0)
			r.value = smooth_hist[0];
		if (hist_fill == HISTORY_DEPTH) begin
			r.armed = 1'b1;
			rise = int'(smooth_hist[0]) - int'(smooth_hist[HISTORY_DEPTH - 1]);
			if (rise >= int'(rise_min))
				r.alarm = 1'b1;
			hot = 0;
			for (i = 0; i < HISTORY_DEPTH; i++)
				if (smooth_hist[i] >= hot_level)
					hot++;
			if (hot >= int'(hot_needed))
				r.alarm = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_win = '{default: '0};
			smooth_hist = '{default: '0};
			raw_fill = 0;
			hist_fill = 0;
			rise_min = RISE_RST;
			hot_level = FIRE_RST;
			hot_needed = NEED_RST;
			expected_readings.delete();
			mismatches = 0;
			reading_no = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[2 +: REG_IDX_W])
					REG_RISE: rise_min = pwdata[RISE_W-1:0];
					REG_FIRE: hot_level = pwdata[SAMPLE_W-1:0];
					REG_NEED: hot_needed = pwdata[NEED_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_readings.push_back(smooth_and_detect(sample));
			if (out_valid && !out_stall) begin
				got = {smoothed_value, smoothed_valid, armed, alarm};
				if (expected_readings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: reading %0d arrived with none pending", $realtime,
							reading_no);
				end else begin
					want = expected_readings.pop_front();
					if (got.value !== want.value || got.valid !== want.valid ||
							got.armed !== want.armed || got.alarm !== want.alarm) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: reading %0d expected %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
								$realtime, reading_no, want.value, want.valid, want.armed,
								want.alarm, got.value, got.valid, got.armed, got.alarm);
					end
				end
				reading_no++;
			end
			failures <= mismatches;
			outstanding <= expected_readings.size();
		end
	end

endmodule

>>> tb/smoothed_fire_alarm_detector_tb.sv
module smoothed_fire_alarm_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfad_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 110;
	localparam int DIRECTED_N = 25;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_W-1:0] smoothed_value;
	logic smoothed_valid;
	logic armed;
	logic alarm;

	int failures;
	int outstanding;
	int long_holds_asked = 0;
	bit gaps_on = 1'b1;

	int directed_samples [DIRECTED_N] = '{
		0, 32767, 32767, 32767, 32767, 32767,
		-32768, -32768, -32768, -32768, -32768,
		-1, -2, 0, 0, 0,
		1, 1, 1, 1, 0,
		-7, -9, 21845, -21846
	};

	smoothed_fire_alarm_detector u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.smoothed_value(smoothed_value),
		.smoothed_valid(smoothed_valid),
		.armed(armed),
		.alarm(alarm)
	);

	smoothed_fire_alarm_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.smoothed_value(smoothed_value),
		.smoothed_valid(smoothed_valid),
		.armed(armed),
		.alarm(alarm),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("smoothed_fire_alarm_detector_tb failed");
		$finish;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		int gap;
		int r;
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (in_stall);
		gap = 0;
		if (gaps_on) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(1, 3);
			else if (r < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: random stall pattern, plus long holds on request
	initial begin
		int holds_done;
		int dur;
		int r;
		holds_done = 0;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (long_holds_asked != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				dur = LONG_HOLD;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					out_stall <= 1'b0;
					dur = $urandom_range(1, 20);
				end else if (r < 50) begin
					out_stall <= 1'b0;
					dur = $urandom_range(100, 300);
				end else if (r < 85) begin
					out_stall <= 1'b1;
					dur = $urandom_range(1, 3);
				end else if (r < 97) begin
					out_stall <= 1'b1;
					dur = $urandom_range(4, 12);
				end else begin
					out_stall <= 1'b1;
					dur = $urandom_range(20, 60);
				end
			end
			repeat (dur) @(posedge clk);
		end
	end

	initial begin
		int ph;
		int left;
		int chunk;
		int k;
		int mode;
		int base;
		int slope;
		int v;
		int i;
		logic [RISE_W-1:0] rise_cfg;
		logic signed [SAMPLE_W-1:0] fire_cfg;
		logic [NEED_W-1:0] need_cfg;
		logic [PDATA_W-1:0] word;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		sample <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_UNMAPPED, $urandom);
		for (i = 0; i < DIRECTED_N; i++)
			send_sample(directed_samples[i][SAMPLE_W-1:0]);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					rise_cfg = '0;
					fire_cfg = 16'sh8000;
					need_cfg = '0;
				end
				1: begin
					rise_cfg = '1;
					fire_cfg = 16'sh7fff;
					need_cfg = '1;
				end
				2: begin
					rise_cfg = RISE_RST;
					fire_cfg = FIRE_RST;
					need_cfg = NEED_RST;
				end
				3: begin
					rise_cfg = '0;
					fire_cfg = '0;
					need_cfg = NEED_W'(HISTORY_DEPTH);
				end
				4: begin
					rise_cfg = RISE_W'(1);
					fire_cfg = 16'sh8000;
					need_cfg = NEED_W'(HISTORY_DEPTH);
				end
				default: begin
					if ($urandom_range(0, 9) < 3)
						rise_cfg = RISE_W'($urandom_range(0, 40));
					else
						rise_cfg = RISE_W'($urandom_range(0, 1023));
					v = int'($urandom_range(0, 500)) - 200;
					fire_cfg = v[SAMPLE_W-1:0];
					need_cfg = NEED_W'($urandom_range(0, 31));
				end
			endcase

			wait_drained();
			word = $urandom;
			word[RISE_W-1:0] = rise_cfg;
			write_reg(REG_RISE, word);
			word = $urandom;
			word[SAMPLE_W-1:0] = fire_cfg;
			write_reg(REG_FIRE, word);
			word = $urandom;
			word[NEED_W-1:0] = need_cfg;
			write_reg(REG_NEED, word);
			if (ph % 5 == 3)
				write_reg(REG_UNMAPPED, $urandom);
			if (ph == 4 || ph == 9)
				long_holds_asked <= long_holds_asked + 1;
			gaps_on = (ph % 4 != 3);

			left = PHASE_ITEMS;
			while (left > 0) begin
				chunk = $urandom_range(8, 40);
				if (chunk > left)
					chunk = left;
				mode = $urandom_range(0, 99);
				slope = int'(rise_cfg) / (HISTORY_DEPTH - 1) + int'($urandom_range(0, 4)) - 2;
				if ($urandom_range(0, 3) == 0)
					slope = -slope;
				base = int'(fire_cfg) - slope * (chunk / 2) + int'($urandom_range(0, 120)) - 60;
				for (k = 0; k < chunk; k++) begin
					if (mode < 65)
						v = base + slope * k + int'($urandom_range(0, 6)) - 3;
					else if (mode < 85)
						v = int'($urandom_range(0, 65535)) - 32768;
					else begin
						case ($urandom_range(0, 3))
							0: v = 32767;
							1: v = -32768;
							2: v = 0;
							default: v = -1;
						endcase
					end
					if (v > 32767)
						v = 32767;
					else if (v < -32768)
						v = -32768;
					send_sample(v[SAMPLE_W-1:0]);
				end
				left -= chunk;
			end
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (failures == 0)
			$display("smoothed_fire_alarm_detector_tb passed");
		else
			$display("smoothed_fire_alarm_detector_tb failed");
		$finish;
	end

endmodule
